// File: sv/eod_pkg.sv
package eod_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int ENERGY_W      = 31;
	localparam int HISTORY_DEPTH = 8;
	localparam int POS_W         = $clog2(HISTORY_DEPTH);
	localparam int SUM_W         = ENERGY_W + POS_W;
	localparam int INTERVAL_W    = 18;
	localparam int Q15_W         = 16;
	localparam int Q15_FRAC      = 15;

	localparam logic [INTERVAL_W-1:0] SINCE_MAX     = '1;
	localparam logic [Q15_W-1:0]      Q15_ONE       = Q15_W'(32768);
	localparam logic [ENERGY_W-1:0]   THRESHOLD_RST = ENERGY_W'(3221225);
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = INTERVAL_W'(2400);

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_INTERVAL  = 2'd1
	} cfg_reg_t;

	localparam int OUT_FIELDS_W = 1 + 2 * Q15_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

// File: sv/energy_onset_detector.sv
// Energy onset detector. Each sample (signed Q1.15) on the slave stream is squared, kept in
// a ring of the last eight energies held in a synchronous memory, and folded into a running
// sum whose eighth is the mean energy. An onset is flagged when the mean rises above the
// previous sample's mean by more than energy_threshold (Q2.30), and either no onset has
// been seen yet or more than min_interval samples have passed since the last one. With an
// onset come velocity = min(1, mean*10) and confidence = min(1, rise*5) in Q1.15; otherwise
// all three fields are zero. One result leaves the master stream for every accepted sample.
// The block takes one sample per clock cycle and passes it through stages 1 to 4, each
// registered, before presenting its result on the master side; the rate is set by the ring
// memory's single read and single write per cycle, and the whole pipeline holds while a
// finished result waits on the master side. After reset, unwritten ring slots count as zero
// through per-slot valid bits, without a clearing pass. Configuration writes are taken at
// any cycle but are meant to land only while no sample is in flight.
module energy_onset_detector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [eod_pkg::SAMPLE_W-1:0]         s_tdata,   // [15:0] sample
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [eod_pkg::OUT_DATA_W-1:0]       m_tdata,   // [0] onset, [16:1] velocity,
	                                                        // [32:17] confidence, rest zero
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [eod_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [eod_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import eod_pkg::*;

	logic [ENERGY_W-1:0]   threshold_q;
	logic [INTERVAL_W-1:0] interval_q;

	logic [ENERGY_W-1:0]      ring_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] ring_vld_q;
	logic [POS_W-1:0]         wr_pos_q;

	logic                  adv;
	logic                  take;
	logic [SAMPLE_W-1:0]   mag;

	logic                  vld_s1;
	logic [ENERGY_W-1:0]   energy_s1;
	logic [ENERGY_W-1:0]   old_s1;
	logic                  old_vld_s1;
	logic [POS_W-1:0]      pos_s1;

	logic [SUM_W-1:0]      sum_q;
	logic [SUM_W-1:0]      sum_new;

	logic                  vld_s2;
	logic [ENERGY_W-1:0]   mean_s2;

	logic [ENERGY_W-1:0]   prev_mean_q;
	logic [INTERVAL_W-1:0] since_q;
	logic                  seen_q;
	logic [ENERGY_W:0]     rise;
	logic [INTERVAL_W-1:0] since_inc;
	logic                  allowed;
	logic                  hit;

	logic                  vld_s3;
	logic                  onset_s3;
	logic [ENERGY_W-1:0]   mean_s3;
	logic [ENERGY_W-1:0]   rise_s3;

	logic [ENERGY_W+3:0]   vel_prod;
	logic [ENERGY_W+2:0]   conf_prod;
	logic [Q15_W-1:0]      velocity;
	logic [Q15_W-1:0]      confidence;

	logic                  out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// The whole pipeline moves together; it stalls only while a result is not taken.
	assign adv       = !out_vld_q || m_tready;
	assign s_tready  = adv;
	assign take      = adv && s_tvalid;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			interval_q  <= INTERVAL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data[ENERGY_W-1:0];
				REG_INTERVAL:  interval_q  <= cfg_data[INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	assign mag = s_tdata[SAMPLE_W-1] ? (SAMPLE_W'(0) - s_tdata) : s_tdata;

	// Stage 1: square the sample and read the ring slot it will replace.
	always_ff @(posedge clk) begin
		if (take) begin
			energy_s1 <= ENERGY_W'(mag) * ENERGY_W'(mag);
			old_s1    <= ring_mem[wr_pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			old_vld_s1 <= 1'b0;
			pos_s1     <= '0;
			wr_pos_q   <= '0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			if (s_tvalid) begin
				old_vld_s1 <= ring_vld_q[wr_pos_q];
				pos_s1     <= wr_pos_q;
				wr_pos_q   <= (wr_pos_q == POS_W'(HISTORY_DEPTH - 1)) ? '0 : wr_pos_q + 1'b1;
			end
		end
	end

	// Stage 2: update the running sum and write the new energy back. The slot read by the
	// sample entering now is never the one written here, since the ring holds two or more.
	assign sum_new = sum_q - SUM_W'(old_vld_s1 ? old_s1 : '0) + SUM_W'(energy_s1);

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			ring_mem[pos_s1] <= energy_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			sum_q      <= '0;
			vld_s2     <= 1'b0;
			mean_s2    <= '0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				ring_vld_q[pos_s1] <= 1'b1;
				sum_q              <= sum_new;
				mean_s2            <= ENERGY_W'(sum_new / HISTORY_DEPTH);
			end
		end
	end

	// Stage 3: onset decision and interval bookkeeping.
	assign rise      = {1'b0, mean_s2} - {1'b0, prev_mean_q};
	assign since_inc = (seen_q && since_q != SINCE_MAX) ? since_q + 1'b1 : since_q;
	assign allowed   = !seen_q || since_inc == SINCE_MAX || since_inc > interval_q;
	assign hit       = !rise[ENERGY_W] && rise[ENERGY_W-1:0] > threshold_q && allowed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mean_q <= '0;
			since_q     <= '0;
			seen_q      <= 1'b0;
			vld_s3      <= 1'b0;
			onset_s3    <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
			if (vld_s2) begin
				prev_mean_q <= mean_s2;
				onset_s3    <= hit;
				if (hit) begin
					since_q <= '0;
					seen_q  <= 1'b1;
				end else begin
					since_q <= since_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s2) begin
			mean_s3 <= mean_s2;
			rise_s3 <= rise[ENERGY_W-1:0];
		end
	end

	// Stage 4: scale to Q1.15 with saturation at one.
	assign vel_prod  = {1'b0, mean_s3, 3'b000} + {3'b000, mean_s3, 1'b0};
	assign conf_prod = {1'b0, rise_s3, 2'b00} + {3'b000, rise_s3};

	always_comb begin
		if ((vel_prod >> Q15_FRAC) > (ENERGY_W + 4)'(Q15_ONE)) begin
			velocity = Q15_ONE;
		end else begin
			velocity = vel_prod[Q15_FRAC +: Q15_W];
		end
		if ((conf_prod >> Q15_FRAC) > (ENERGY_W + 3)'(Q15_ONE)) begin
			confidence = Q15_ONE;
		end else begin
			confidence = conf_prod[Q15_FRAC +: Q15_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s3) begin
			out_data_q <= OUT_DATA_W'({onset_s3 ? confidence : '0,
			                           onset_s3 ? velocity : '0,
			                           onset_s3});
		end
	end

endmodule
